// ===== sv/assert_macros.svh =====
// Assertion macros for the bitmap decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CHK_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bmp32 check failed");

// Next-cycle implication, disabled while in reset.
`define CHK_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bmp32 check failed");

`endif

// ===== sv/bmp32_pkg.sv =====
// Types and constants for the 32-bit bitfields bitmap stream decoder.
package bmp32_pkg;

  localparam int unsigned MAX_SIDE_DEF = 65535;
  localparam logic [5:0]  HDR_LAST_POS = 6'd53;
  localparam logic [5:0]  SIG_CHECK_POS = 6'd13;
  localparam logic [31:0] HDR_BYTES = 32'd54;
  localparam logic [15:0] SIGNATURE = 16'h4D42;
  localparam logic [31:0] MIN_INFO_SIZE = 32'd40;
  localparam logic [15:0] BPP_32 = 16'd32;
  localparam logic [31:0] COMP_BITFIELDS = 32'd3;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_SIGNATURE   = 3'd1,
    ERR_UNSUPPORTED = 3'd2,
    ERR_OFFSET      = 3'd3,
    ERR_TRUNCATED   = 3'd4
  } err_t;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_SKIP   = 5'b00010,
    PH_PIXELS = 5'b00100,
    PH_DONE   = 5'b01000,
    PH_HALTED = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    err_t        error_code;
    logic [15:0] column;
    logic [15:0] row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        bottom_up;
    logic        last_pixel;
  } out_item_t;

  // Summary of the captured header, from the field store to the parser.
  typedef struct packed {
    logic        ok;
    logic        offset_low;
    logic        offset_beyond;
    logic [31:0] offset;
    logic [15:0] width;
    logic [15:0] height;
    logic        neg_height;
  } hdr_info_t;

endpackage

// ===== sv/bmp32_stream_decoder.sv =====
// Top level of the 32-bit bitfields bitmap stream decoder.
// Usage:
//   in channel  (in_valid/in_ready/in_data): one file byte per transfer, with
//     first_byte marking byte 0 of a file and end_of_file the final byte.
//   out channel (out_valid/out_ready/out_data): at most one result per input
//     byte: header accepted, a pixel (column, row, RGB) or an error.
// Rate: one byte per cycle while the output register is empty or being drained.
//   A byte is parsed in the cycle it is taken and its result is registered in the
//   output register. The header field store, the pixel counters and the single
//   output register set this rate; parse state updates once per byte.
// Stall: in_ready is high while the output register is empty or being
//   drained, so a stalled receiver holds back at most one result and input
//   stops until it is taken.
// Reset: synchronous rst clears the parser to the header phase and empties
//   the output register; parsing starts at byte 0 whether or not first_byte
//   is given. After an error, bytes are dropped until the next first_byte.
module bmp32_stream_decoder import bmp32_pkg::*; #(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  `include "assert_macros.svh"

  phase_t      phase, phase_next, ph_c;
  logic [31:0] pos, pos_next, pos_c;
  logic [23:0] pbuf, pbuf_next, pbuf_c;
  logic [1:0]  bip, bip_next, bip_c;
  logic [15:0] col, col_next, col_c;
  logic [15:0] row, row_next, row_c;
  logic        in_fire;
  logic        first;
  logic        eof;
  logic        do_pix;
  logic        last;
  logic        has_res;
  err_t        err;
  out_item_t   res;
  hdr_info_t   info;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign first    = in_data.first_byte;
  assign eof      = in_data.end_of_file;

  bmp32_hdr #(.MAX_SIDE(MAX_SIDE)) u_hdr (
    .clk       (clk),
    .rst       (rst),
    .clr       (in_fire && first),
    .cap       (in_fire && (ph_c == PH_HEADER)),
    .pos       (pos_c[5:0]),
    .data_byte (in_data.data_byte),
    .info      (info)
  );

  // a first byte restarts the file from clean state
  always_comb begin
    ph_c   = first ? PH_HEADER : phase;
    pos_c  = first ? '0 : pos;
    pbuf_c = first ? '0 : pbuf;
    bip_c  = first ? '0 : bip;
    col_c  = first ? '0 : col;
    row_c  = first ? '0 : row;
  end

  always_comb begin
    phase_next = ph_c;
    pos_next   = (pos_c == '1) ? pos_c : pos_c + 32'd1;
    pbuf_next  = pbuf_c;
    bip_next   = bip_c;
    col_next   = col_c;
    row_next   = row_c;
    res        = '0;
    has_res    = 1'b0;
    err        = ERR_NONE;
    do_pix     = 1'b0;
    last       = 1'b0;

    unique case (ph_c)
      PH_HEADER: begin
        if (pos_c[5:0] == 6'd0) pbuf_next[7:0] = in_data.data_byte;
        if (pos_c[5:0] == 6'd1) pbuf_next[15:8] = in_data.data_byte;
        if (pos_c[5:0] == SIG_CHECK_POS && pbuf_c[15:0] != SIGNATURE) begin
          err = ERR_SIGNATURE;
        end else if (pos_c[5:0] == HDR_LAST_POS && !info.ok) begin
          err = ERR_UNSUPPORTED;
        end else if (pos_c[5:0] == HDR_LAST_POS && info.offset_low) begin
          err = ERR_OFFSET;
        end else if (eof) begin
          err = ERR_TRUNCATED;
        end else if (pos_c[5:0] == HDR_LAST_POS) begin
          pbuf_next          = '0;
          phase_next         = info.offset_beyond ? PH_SKIP : PH_PIXELS;
          has_res            = 1'b1;
          res.kind           = KIND_HEADER;
          res.image_width    = info.width;
          res.image_height   = info.height;
          res.bottom_up      = !info.neg_height;
        end
      end
      PH_SKIP: begin
        if (pos_c >= info.offset) begin
          phase_next = PH_PIXELS;
          do_pix     = 1'b1;
        end else if (eof) begin
          err = ERR_TRUNCATED;
        end
      end
      PH_PIXELS: do_pix = 1'b1;
      default: ;
    endcase

    if (do_pix) begin
      if (bip_c != 2'd3) begin
        pbuf_next[{bip_c, 3'b000} +: 8] = in_data.data_byte;
        bip_next = bip_c + 2'd1;
        if (eof) err = ERR_TRUNCATED;
      end else begin
        last = ({1'b0, col_c} + 17'd1 == {1'b0, info.width}) &&
               ({1'b0, row_c} + 17'd1 == {1'b0, info.height});
        if (eof && !last) begin
          err = ERR_TRUNCATED;
        end else begin
          has_res        = 1'b1;
          res.kind       = KIND_PIXEL;
          res.column     = col_c;
          res.row        = info.neg_height ? row_c : info.height - 16'd1 - row_c;
          res.red        = pbuf_c[23:16];
          res.green      = pbuf_c[15:8];
          res.blue       = pbuf_c[7:0];
          res.last_pixel = last;
          pbuf_next      = '0;
          bip_next       = '0;
          if (last) begin
            phase_next = PH_DONE;
          end else if ({1'b0, col_c} + 17'd1 >= {1'b0, info.width}) begin
            col_next = '0;
            row_next = row_c + 16'd1;
          end else begin
            col_next = col_c + 16'd1;
          end
        end
      end
    end

    if (err != ERR_NONE) begin
      phase_next     = PH_HALTED;
      has_res        = 1'b1;
      res            = '0;
      res.kind       = KIND_ERROR;
      res.error_code = err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      pos   <= '0;
      pbuf  <= '0;
      bip   <= '0;
      col   <= '0;
      row   <= '0;
    end else if (in_fire) begin
      phase <= phase_next;
      pos   <= pos_next;
      pbuf  <= pbuf_next;
      bip   <= bip_next;
      col   <= col_next;
      row   <= row_next;
    end
  end

  // result register; a transfer on the output frees it for the next byte
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= has_res;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && has_res) begin
      out_data <= res;
    end
  end

  `CHK_IMP(a_ready_when_empty, clk, rst, !out_valid, in_ready)
  `CHK_NXT(a_final_phase_holds, clk, rst, in_fire && !in_data.first_byte && (phase == PH_DONE || phase == PH_HALTED), phase == $past(phase))
  `CHK_IMP(a_header_counters_clear, clk, rst, phase == PH_HEADER, bip == 2'd0 && col == 16'd0 && row == 16'd0)

endmodule

// ===== sv/bmp32_hdr.sv =====
// Header field store and header acceptance check.
module bmp32_hdr import bmp32_pkg::*; #(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       clr,
  input  logic       cap,
  input  logic [5:0] pos,
  input  logic [7:0] data_byte,
  output hdr_info_t  info
);

  logic [31:0] offset;
  logic [31:0] info_size;
  logic [31:0] width_f;
  logic [31:0] height_f;
  logic [15:0] planes;
  logic [15:0] bpp;
  logic [31:0] compr;
  logic [1:0]  lane;
  logic [31:0] abs_h;

  // every field but bpp starts two bytes past a multiple of four; two-byte fields use only lane[0]
  assign lane = pos[1:0] - 2'd2;

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      offset    <= '0;
      info_size <= '0;
      width_f   <= '0;
      height_f  <= '0;
      planes    <= '0;
      bpp       <= '0;
      compr     <= '0;
    end else if (cap) begin
      if (pos >= 6'd10 && pos < 6'd14) offset[{lane, 3'b000} +: 8] <= data_byte;
      if (pos >= 6'd14 && pos < 6'd18) info_size[{lane, 3'b000} +: 8] <= data_byte;
      if (pos >= 6'd18 && pos < 6'd22) width_f[{lane, 3'b000} +: 8] <= data_byte;
      if (pos >= 6'd22 && pos < 6'd26) height_f[{lane, 3'b000} +: 8] <= data_byte;
      if (pos >= 6'd26 && pos < 6'd28) planes[{lane[0], 3'b000} +: 8] <= data_byte;
      if (pos >= 6'd28 && pos < 6'd30) bpp[{lane[0], 3'b000} +: 8] <= data_byte;
      if (pos >= 6'd30 && pos < 6'd34) compr[{lane, 3'b000} +: 8] <= data_byte;
    end
  end

  assign abs_h = height_f[31] ? (~height_f + 32'd1) : height_f;

  always_comb begin
    info.ok = (info_size >= MIN_INFO_SIZE) && !width_f[31] && (width_f != '0) &&
              (width_f <= 32'(MAX_SIDE)) && (height_f != '0) &&
              (abs_h <= 32'(MAX_SIDE)) && (planes == 16'd1) && (bpp == BPP_32) &&
              (compr == COMP_BITFIELDS);
    info.offset_low    = offset < HDR_BYTES;
    info.offset_beyond = offset > HDR_BYTES;
    info.offset        = offset;
    info.width         = width_f[15:0];
    info.height        = abs_h[15:0];
    info.neg_height    = height_f[31];
  end

endmodule

// ===== dv/bmp32_scoreboard_pkg.sv =====
// Scoreboard class for the bitmap decoder testbench: byte-level decode and result checks.
package bmp32_scoreboard_pkg;
  import bmp32_pkg::*;

  class pixel_stream_scoreboard;
    phase_t      phase;
    logic [31:0] pos;
    logic [31:0] pix_offset;
    logic [31:0] info_size;
    logic [31:0] width_f;
    logic [31:0] height_f;
    logic [31:0] comp_f;
    logic [15:0] planes;
    logic [15:0] bpp;
    logic [15:0] col;
    logic [15:0] row;
    logic [23:0] pix_bytes;
    logic [1:0]  byte_idx;

    out_item_t due_results[$];
    int        mismatches;
    int        n_headers;
    int        n_pixels;
    int        n_errs[5];

    function new();
      restart();
      mismatches = 0;
      n_headers = 0;
      n_pixels = 0;
      foreach (n_errs[i]) n_errs[i] = 0;
    endfunction

    function void restart();
      phase = PH_HEADER;
      pos = '0;
      pix_offset = '0;
      info_size = '0;
      width_f = '0;
      height_f = '0;
      comp_f = '0;
      planes = '0;
      bpp = '0;
      col = '0;
      row = '0;
      pix_bytes = '0;
      byte_idx = '0;
    endfunction

    function logic [31:0] abs_height();
      return height_f[31] ? -height_f : height_f;
    endfunction

    // little-endian slice of a header field carried by byte p
    function logic [31:0] field_part(logic [31:0] p, int base, int len, logic [7:0] b);
      if (p >= base && p < base + len) return 32'(b) << (8 * (p - base));
      return '0;
    endfunction

    function bit header_fits();
      logic [31:0] h_abs;
      h_abs = abs_height();
      return info_size >= MIN_INFO_SIZE && !width_f[31] && width_f != 0 &&
             width_f <= MAX_SIDE_DEF && height_f != 0 && h_abs <= MAX_SIDE_DEF &&
             planes == 16'd1 && bpp == BPP_32 && comp_f == COMP_BITFIELDS;
    endfunction

    function out_item_t halt(err_t code);
      out_item_t r;
      r = '0;
      r.kind = KIND_ERROR;
      r.error_code = code;
      phase = PH_HALTED;
      return r;
    endfunction

    function bit header_byte(logic [31:0] p, in_item_t it, output out_item_t r);
      logic [7:0]  b;
      logic [31:0] h_abs;
      r = '0;
      b = it.data_byte;
      pix_bytes  |= 24'(field_part(p, 0, 2, b));
      pix_offset |= field_part(p, 10, 4, b);
      info_size  |= field_part(p, 14, 4, b);
      width_f    |= field_part(p, 18, 4, b);
      height_f   |= field_part(p, 22, 4, b);
      planes     |= 16'(field_part(p, 26, 2, b));
      bpp        |= 16'(field_part(p, 28, 2, b));
      comp_f     |= field_part(p, 30, 4, b);
      if (p == 32'(SIG_CHECK_POS) && pix_bytes != 24'(SIGNATURE)) begin
        r = halt(ERR_SIGNATURE);
        return 1'b1;
      end
      if (p == 32'(HDR_LAST_POS)) begin
        if (!header_fits()) begin
          r = halt(ERR_UNSUPPORTED);
          return 1'b1;
        end
        if (pix_offset < HDR_BYTES) begin
          r = halt(ERR_OFFSET);
          return 1'b1;
        end
      end
      if (it.end_of_file) begin
        r = halt(ERR_TRUNCATED);
        return 1'b1;
      end
      if (p == 32'(HDR_LAST_POS)) begin
        pix_bytes = '0;
        if (pix_offset > HDR_BYTES) phase = PH_SKIP;
        else phase = PH_PIXELS;
        h_abs = abs_height();
        r.kind = KIND_HEADER;
        r.image_width = width_f[15:0];
        r.image_height = h_abs[15:0];
        r.bottom_up = ~height_f[31];
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit pixel_byte(in_item_t it, output out_item_t r);
      logic [15:0] w;
      logic [15:0] h;
      logic [31:0] h_abs;
      bit          last;
      r = '0;
      if (byte_idx < 2'd3) begin
        pix_bytes |= 24'(it.data_byte) << (8 * byte_idx);
        byte_idx++;
        if (it.end_of_file) begin
          r = halt(ERR_TRUNCATED);
          return 1'b1;
        end
        return 1'b0;
      end
      w = width_f[15:0];
      h_abs = abs_height();
      h = h_abs[15:0];
      last = (32'(col) + 1 == 32'(w)) && (32'(row) + 1 == 32'(h));
      if (it.end_of_file && !last) begin
        r = halt(ERR_TRUNCATED);
        return 1'b1;
      end
      r.kind = KIND_PIXEL;
      r.column = col;
      r.row = height_f[31] ? row : h - 16'd1 - row;
      r.red = pix_bytes[23:16];
      r.green = pix_bytes[15:8];
      r.blue = pix_bytes[7:0];
      r.last_pixel = last;
      pix_bytes = '0;
      byte_idx = '0;
      if (last) begin
        phase = PH_DONE;
      end else if (32'(col) + 1 >= 32'(w)) begin
        col = '0;
        row++;
      end else begin
        col++;
      end
      return 1'b1;
    endfunction

    function bit decode_byte(in_item_t it, output out_item_t r);
      logic [31:0] p;
      bit          have;
      r = '0;
      have = 1'b0;
      if (it.first_byte) restart();
      p = pos;
      case (phase)
        PH_HEADER: have = header_byte(p, it, r);
        PH_SKIP: begin
          if (p >= pix_offset) begin
            phase = PH_PIXELS;
            have = pixel_byte(it, r);
          end else if (it.end_of_file) begin
            r = halt(ERR_TRUNCATED);
            have = 1'b1;
          end
        end
        PH_PIXELS: have = pixel_byte(it, r);
        default: have = 1'b0;
      endcase
      if (pos != '1) pos++;
      return have;
    endfunction

    function void note_byte(in_item_t it);
      out_item_t r;
      if (decode_byte(it, r)) due_results.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        $error("result of kind %0d with nothing pending", got.kind);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      case (want.kind)
        KIND_PIXEL:  n_pixels++;
        KIND_HEADER: n_headers++;
        default:     n_errs[int'(want.error_code)]++;
      endcase
      check_field("kind", want.kind, got.kind);
      check_field("error_code", want.error_code, got.error_code);
      check_field("column", want.column, got.column);
      check_field("row", want.row, got.row);
      check_field("red", want.red, got.red);
      check_field("green", want.green, got.green);
      check_field("blue", want.blue, got.blue);
      check_field("image_width", want.image_width, got.image_width);
      check_field("image_height", want.image_height, got.image_height);
      check_field("bottom_up", want.bottom_up, got.bottom_up);
      check_field("last_pixel", want.last_pixel, got.last_pixel);
    endfunction
  endclass

endpackage

// ===== dv/tb_bmp32_stream_decoder.sv =====
// Testbench for the bitmap stream decoder: directed and random files, both sides stalled.
module tb_bmp32_stream_decoder import bmp32_pkg::*, bmp32_scoreboard_pkg::*;;

  localparam int BYTE_BUDGET = 1350;
  localparam int HOLD_CYCLES = 200;
  localparam int IDLE_LIMIT = 3000;

  typedef enum int {
    F_SIGNATURE, F_INFO_SIZE, F_WIDTH, F_HEIGHT, F_PLANES, F_BITS, F_COMPRESSION,
    F_OFFSET, F_SIG_AND_OFFSET
  } fault_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  in_item_t  in_data = '0;
  logic      in_ready;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  pixel_stream_scoreboard sb;
  logic [7:0] file_q[$];
  bit  steady_tx = 1'b0;
  bit  steady_rx = 1'b0;
  bit  hold_rx = 1'b0;
  int  holds_done = 0;
  int  n_bytes = 0;
  int  n_files = 0;
  int  idle_cycles = 0;

  bmp32_stream_decoder DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_pause(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic void put_le(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) file_q.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_random(int n);
    repeat (n) file_q.push_back(8'($urandom));
  endfunction

  function automatic void put_header(logic [15:0] sig, logic [31:0] off, logic [31:0] isz,
                                     logic [31:0] w, logic [31:0] h, logic [15:0] pl,
                                     logic [15:0] bits, logic [31:0] comp);
    file_q.delete();
    put_le(sig, 2);
    put_random(8);
    put_le(off, 4);
    put_le(isz, 4);
    put_le(w, 4);
    put_le(h, 4);
    put_le(pl, 2);
    put_le(bits, 2);
    put_le(comp, 4);
    put_random(20);
  endfunction

  // negative h gives a top-down image
  function automatic void good_image(int w, int h, int gap);
    logic [31:0] isz;
    isz = MIN_INFO_SIZE + 32'(16 * $urandom_range(0, 5));
    put_header(SIGNATURE, HDR_BYTES + 32'(gap), isz, 32'(w), 32'(h), 16'd1, BPP_32,
               COMP_BITFIELDS);
    put_random(gap);
    put_random(4 * w * (h < 0 ? -h : h));
  endfunction

  function automatic void bad_header(fault_t f);
    logic [15:0] sig;
    logic [31:0] off;
    logic [31:0] isz;
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] comp;
    logic [15:0] pl;
    logic [15:0] bits;
    sig = SIGNATURE;
    off = HDR_BYTES;
    isz = MIN_INFO_SIZE;
    w = 32'd2;
    h = 32'd2;
    comp = COMP_BITFIELDS;
    pl = 16'd1;
    bits = BPP_32;
    case (f)
      F_SIGNATURE:   sig = SIGNATURE ^ 16'(1 << $urandom_range(0, 15));
      F_INFO_SIZE:   isz = $urandom_range(0, 39);
      F_WIDTH: begin
        case ($urandom_range(0, 2))
          0: w = '0;
          1: w = 32'h8000_0000 | $urandom;
          default: w = 32'd65536 + $urandom_range(0, 1000);
        endcase
      end
      F_HEIGHT: begin
        case ($urandom_range(0, 3))
          0: h = '0;
          1: h = 32'hFFFF_0000;
          2: h = 32'd65536;
          default: h = 32'h8000_0000;
        endcase
      end
      F_PLANES:      pl = 16'd1 ^ 16'($urandom_range(1, 65535));
      F_BITS:        bits = BPP_32 ^ 16'($urandom_range(1, 65535));
      F_COMPRESSION: comp = COMP_BITFIELDS ^ $urandom_range(1, 32'hFFFF_FFFF);
      F_OFFSET:      off = $urandom_range(0, 53);
      default: begin
        sig = SIGNATURE ^ 16'h0100;
        off = $urandom_range(0, 53);
      end
    endcase
    put_header(sig, off, isz, w, h, pl, bits, comp);
  endfunction

  task automatic send_byte(in_item_t it);
    repeat (pick_pause(steady_tx)) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(it);
    n_bytes++;
  endtask

  task automatic send_file(bit first, int eof_at, int upto);
    in_item_t it;
    steady_tx = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < upto; i++) begin
      it.data_byte = file_q[i];
      it.first_byte = first && (i == 0);
      it.end_of_file = (i == eof_at);
      send_byte(it);
    end
    n_files++;
  endtask

  task automatic send_noise();
    in_item_t it;
    repeat ($urandom_range(1, 16)) begin
      it.data_byte = 8'($urandom);
      it.first_byte = ($urandom_range(0, 7) == 0);
      it.end_of_file = ($urandom_range(0, 5) == 0);
      send_byte(it);
    end
  endtask

  task automatic directed_files();
    // receiver holds off during the first file, so the header result backs up the input
    hold_rx = 1'b1;
    // first file after reset has no first_byte
    good_image(2, 2, 0);
    send_file(1'b0, file_q.size() - 1, file_q.size());
    // skipped gap before pixels, trailing bytes after the last pixel
    good_image(1, -1, 4);
    put_random(3);
    send_file(1'b1, file_q.size() - 1, file_q.size());
    // every header fault, followed by bytes that must stay silent
    for (int k = 0; k <= int'(F_SIG_AND_OFFSET); k++) begin
      bad_header(fault_t'(k));
      put_random(6);
      send_file(1'b1, -1, file_q.size());
    end
    // fault priority against end of file on the check bytes
    bad_header(F_SIGNATURE);
    send_file(1'b1, 13, 20);
    bad_header(F_WIDTH);
    send_file(1'b1, 53, 54);
    bad_header(F_OFFSET);
    send_file(1'b1, 53, 54);
    // early end of file: on the last header byte, in the file header, in the skip,
    // mid-pixel and on a complete pixel that is not the last one
    good_image(1, 1, 0);
    send_file(1'b1, 53, 54);
    good_image(1, 1, 0);
    send_file(1'b1, 7, 8);
    good_image(2, 1, 6);
    send_file(1'b1, 56, 57);
    good_image(2, 1, 0);
    send_file(1'b1, 55, 56);
    good_image(2, 1, 0);
    send_file(1'b1, 57, 58);
    // widest and tallest images, cut off by a restart
    put_header(SIGNATURE, HDR_BYTES, MIN_INFO_SIZE, 32'd65535, 32'hFFFF_FFFF, 16'd1, BPP_32,
               COMP_BITFIELDS);
    put_random(8);
    send_file(1'b1, -1, file_q.size());
    put_header(SIGNATURE, HDR_BYTES, MIN_INFO_SIZE, 32'd1, 32'd65535, 16'd1, BPP_32,
               COMP_BITFIELDS);
    put_random(8);
    send_file(1'b1, -1, file_q.size());
    // restart inside the header
    good_image(1, 1, 0);
    send_file(1'b1, -1, 20);
    good_image(3, -2, 0);
    send_file(1'b1, file_q.size() - 1, file_q.size());
  endtask

  task automatic random_files();
    int  pick;
    int  w;
    int  h;
    int  gap;
    int  eof_at;
    bit  held;
    held = 1'b0;
    while (n_bytes < BYTE_BUDGET) begin
      pick = $urandom_range(0, 99);
      w = $urandom_range(1, 3);
      h = $urandom_range(1, 3);
      if ($urandom_range(0, 1)) h = -h;
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
      if (pick < 55) begin
        good_image(w, h, gap);
        if ($urandom_range(0, 3) == 0) put_random($urandom_range(1, 4));
        eof_at = ($urandom_range(0, 4) == 0) ? -1 : file_q.size() - 1;
        if (!held) begin
          hold_rx = 1'b1;
          held = 1'b1;
        end
        send_file(1'b1, eof_at, file_q.size());
      end else if (pick < 70) begin
        good_image(w, h, gap);
        eof_at = $urandom_range(0, file_q.size() - 2);
        send_file(1'b1, eof_at, eof_at + 1);
      end else if (pick < 85) begin
        bad_header(fault_t'($urandom_range(0, int'(F_SIG_AND_OFFSET))));
        case ($urandom_range(0, 3))
          0: eof_at = -1;
          1: eof_at = 13;
          2: eof_at = 53;
          default: eof_at = $urandom_range(0, 53);
        endcase
        send_file(1'b1, eof_at, file_q.size());
      end else if (pick < 93) begin
        good_image(w, h, gap);
        send_file(1'b1, -1, $urandom_range(1, file_q.size() - 1));
      end else begin
        send_noise();
      end
    end
  endtask

  // result side: random stalls plus a long hold-off on each request
  initial begin
    int len;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) == 0) steady_rx = !steady_rx;
      if (hold_rx) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
        holds_done++;
      end else begin
        len = pick_pause(steady_rx);
        if (len == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (len - 1) @(negedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    directed_files();
    random_files();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Covered %0d files in %0d byte transfers, %0d long receiver hold-off(s)",
             n_files, n_bytes, holds_done);
    $display("Checked %0d headers, %0d pixels; errors sig/hdr/offset/trunc %0d/%0d/%0d/%0d",
             sb.n_headers, sb.n_pixels, sb.n_errs[1], sb.n_errs[2], sb.n_errs[3],
             sb.n_errs[4]);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
